// File: rtl/sspq_pkg.sv
// Shared operation codes and cell command type for the sorted priority queue.
`default_nettype none

package sspq_pkg;

  // Operation codes carried in the input item
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic push;  // insert the new entry at its sorted place
    logic pop;   // shift every entry one cell toward the head
  } sspq_cmd_t;

endpackage

`default_nettype wire

// File: rtl/sspq_ifs.sv
// Valid/ready channel interfaces for the queue's input and result items.
`default_nettype none

interface sspq_in_if #(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [KEY_WIDTH-1:0]     key;
  logic [PAYLOAD_WIDTH-1:0] payload;

  modport source (output valid, output operation, output key, output payload, input ready);
  modport sink   (input valid, input operation, input key, input payload, output ready);
endinterface

interface sspq_out_if #(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic                     pop_valid;
  logic [KEY_WIDTH-1:0]     out_key;
  logic [PAYLOAD_WIDTH-1:0] out_payload;
  logic                     push_dropped;
  logic                     now_empty;

  modport source (output valid, output pop_valid, output out_key, output out_payload,
                  output push_dropped, output now_empty, input ready);
  modport sink   (input valid, input pop_valid, input out_key, input out_payload,
                  input push_dropped, input now_empty, output ready);
endinterface

`default_nettype wire

// File: rtl/sspq_cell.sv
// One cell of the sorted chain: holds a single entry and trades with its neighbors.
`default_nettype none

module sspq_cell
  import sspq_pkg::*;
#(
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sspq_cmd_t                cmd,
  input  wire logic [KEY_WIDTH-1:0]     new_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] new_payload,
  // neighbor toward the head
  input  wire logic                     prev_valid,
  input  wire logic [KEY_WIDTH-1:0]     prev_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] prev_payload,
  input  wire logic                     prev_stays,
  // neighbor toward the tail
  input  wire logic                     next_valid,
  input  wire logic [KEY_WIDTH-1:0]     next_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] next_payload,
  output logic                          valid,
  output logic [KEY_WIDTH-1:0]          key,
  output logic [PAYLOAD_WIDTH-1:0]      payload,
  output logic                          stays
);

  logic                     valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0]     key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;

  // entry keeps its place on a push when it is not larger than the new key
  assign stays = valid_r && (key_r <= new_key);

  always_comb begin
    valid_nxt   = valid_r;
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (cmd.pop) begin
      valid_nxt   = next_valid;
      key_nxt     = next_key;
      payload_nxt = next_payload;
    end else if (cmd.push && !stays) begin
      if (prev_stays) begin
        valid_nxt   = 1'b1;
        key_nxt     = new_key;
        payload_nxt = new_payload;
      end else begin
        valid_nxt   = prev_valid;
        key_nxt     = prev_key;
        payload_nxt = prev_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign valid   = valid_r;
  assign key     = key_r;
  assign payload = payload_r;

endmodule

`default_nettype wire

// File: rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted min-priority queue built as a chain of cells.
`default_nettype none

// Usage:
//   in_chan  (sink): one item per handshake. operation = OP_PUSH inserts key/payload,
//            operation = OP_POP removes the head (smallest key, oldest among equals).
//   out_chan (source): exactly one result item for every accepted input item, in order:
//            pop_valid/out_key/out_payload for a pop, push_dropped for a push into a
//            full queue, now_empty after the step.
//   Result: registered; it shows on out_chan in the cycle after the
//            input item is accepted.
//   Throughput: one item per cycle while out_chan is not stalled. Every cell compares
//            its key with the incoming key in parallel and moves one position at most,
//            so the whole chain of DEPTH cells updates together on a push or a pop.
//   Stall: the output register holds its result while out_chan.ready is low; a new
//            item is still taken in the cycle the old result leaves (ready is
//            !out_valid || out_chan.ready).
//   Reset: synchronous, active low; clears every cell's valid bit (queue empty) and
//            the output valid. Stored keys and payloads are not cleared.
//   Full/empty: a push into a full queue is dropped and flagged; a pop on an empty
//            queue changes nothing and returns zeros with now_empty set.

module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int DEPTH         = 16,
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sspq_in_if.sink    in_chan,
  sspq_out_if.source out_chan
);

  // Per-cell views of the chain
  logic                     cell_valid   [DEPTH];
  logic [KEY_WIDTH-1:0]     cell_key     [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
  logic                     cell_stays   [DEPTH];

  sspq_cmd_t cmd;
  logic      in_accept;
  logic      full;
  logic      empty;

  // Output register
  logic                     out_valid_r;
  logic                     pop_valid_r, pop_valid_nxt;
  logic [KEY_WIDTH-1:0]     out_key_r, out_key_nxt;
  logic [PAYLOAD_WIDTH-1:0] out_payload_r, out_payload_nxt;
  logic                     push_dropped_r, push_dropped_nxt;
  logic                     now_empty_r, now_empty_nxt;

  // Entries are packed toward the head, so the end cells tell full and empty
  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Dropped pushes and empty pops leave the chain untouched
  assign cmd.push = in_accept && (in_chan.operation == OP_PUSH) && !full;
  assign cmd.pop  = in_accept && (in_chan.operation == OP_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     p_valid;
    logic [KEY_WIDTH-1:0]     p_key;
    logic [PAYLOAD_WIDTH-1:0] p_payload;
    logic                     p_stays;
    logic                     n_valid;
    logic [KEY_WIDTH-1:0]     n_key;
    logic [PAYLOAD_WIDTH-1:0] n_payload;

    if (i == 0) begin : g_head
      // head cell: new entry lands here unless the head stays
      assign p_valid   = 1'b0;
      assign p_key     = '0;
      assign p_payload = '0;
      assign p_stays   = 1'b1;
    end else begin : g_mid
      assign p_valid   = cell_valid[i-1];
      assign p_key     = cell_key[i-1];
      assign p_payload = cell_payload[i-1];
      assign p_stays   = cell_stays[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_valid   = 1'b0;
      assign n_key     = '0;
      assign n_payload = '0;
    end else begin : g_body
      assign n_valid   = cell_valid[i+1];
      assign n_key     = cell_key[i+1];
      assign n_payload = cell_payload[i+1];
    end

    sspq_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .new_key      (in_chan.key),
      .new_payload  (in_chan.payload),
      .prev_valid   (p_valid),
      .prev_key     (p_key),
      .prev_payload (p_payload),
      .prev_stays   (p_stays),
      .next_valid   (n_valid),
      .next_key     (n_key),
      .next_payload (n_payload),
      .valid        (cell_valid[i]),
      .key          (cell_key[i]),
      .payload      (cell_payload[i]),
      .stays        (cell_stays[i])
    );
  end

  // Result of the item being accepted, taken from the state before the step
  always_comb begin
    pop_valid_nxt    = 1'b0;
    out_key_nxt      = '0;
    out_payload_nxt  = '0;
    push_dropped_nxt = 1'b0;
    now_empty_nxt    = 1'b0;
    if (in_chan.operation == OP_PUSH) begin
      // any push leaves at least one entry behind
      push_dropped_nxt = full;
    end else begin
      pop_valid_nxt = !empty;
      if (!empty) begin
        out_key_nxt     = cell_key[0];
        out_payload_nxt = cell_payload[0];
      end
      // after the pop the old second entry is the new head
      now_empty_nxt = !cell_valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pop_valid_r    <= pop_valid_nxt;
      out_key_r      <= out_key_nxt;
      out_payload_r  <= out_payload_nxt;
      push_dropped_r <= push_dropped_nxt;
      now_empty_r    <= now_empty_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pop_valid    = pop_valid_r;
  assign out_chan.out_key      = out_key_r;
  assign out_chan.out_payload  = out_payload_r;
  assign out_chan.push_dropped = push_dropped_r;
  assign out_chan.now_empty    = now_empty_r;

endmodule

`default_nettype wire

// File: tb/sspq_checker.sv
// Checker for the sorted priority queue: tracks queue contents and compares each result item.
`timescale 1ns / 1ps

module sspq_checker
  import sspq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sspq_in_if          in_mon,
  sspq_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned results_owed
);

  localparam int QDEPTH = 16;
  localparam int KW     = 16;
  localparam int PW     = 32;

  typedef struct packed {
    logic          pop_valid;
    logic [KW-1:0] key;
    logic [PW-1:0] payload;
    logic          push_dropped;
    logic          now_empty;
  } queue_result_t;

  // Shadow copy of the queue, kept sorted, oldest first among equal keys
  logic [KW-1:0] shadow_keys[QDEPTH];
  logic [PW-1:0] shadow_payloads[QDEPTH];
  int            shadow_count = 0;
  queue_result_t owed_q[$];
  int unsigned   mismatches = 0;

  assign fail_count = mismatches;

  function automatic queue_result_t apply_item(logic op, logic [KW-1:0] k, logic [PW-1:0] p);
    queue_result_t r;
    int slot;
    int i;
    r = '0;
    if (op == OP_PUSH) begin
      if (shadow_count >= QDEPTH) begin
        r.push_dropped = 1'b1;
      end else begin
        // land ahead of the first strictly greater key
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] <= k) slot++;
        for (i = shadow_count; i > slot; i--) begin
          shadow_keys[i]     = shadow_keys[i-1];
          shadow_payloads[i] = shadow_payloads[i-1];
        end
        shadow_keys[slot]     = k;
        shadow_payloads[slot] = p;
        shadow_count++;
      end
    end else if (shadow_count > 0) begin
      r.pop_valid = 1'b1;
      r.key       = shadow_keys[0];
      r.payload   = shadow_payloads[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_keys[i-1]     = shadow_keys[i];
        shadow_payloads[i-1] = shadow_payloads[i];
      end
      shadow_count--;
    end
    r.now_empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      owed_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        owed_q.push_back(apply_item(in_mon.operation, in_mon.key, in_mon.payload));
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $error("result item with nothing outstanding");
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          check_field("pop_valid", 64'(want.pop_valid), 64'(out_mon.pop_valid));
          check_field("out_key", 64'(want.key), 64'(out_mon.out_key));
          check_field("out_payload", 64'(want.payload), 64'(out_mon.out_payload));
          check_field("push_dropped", 64'(want.push_dropped), 64'(out_mon.push_dropped));
          check_field("now_empty", 64'(want.now_empty), 64'(out_mon.now_empty));
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// File: tb/tb_stable_sorted_priority_queue.sv
// Testbench top for the stable sorted priority queue: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue;
  import sspq_pkg::*;

  localparam int RANDOM_ITEMS = 1427;  // plus the directed items, about 1450 total

  logic clk;
  logic rst_n;
  bit   no_idle;  // set during burst phases: neither side inserts gaps

  int unsigned fail_count;
  int unsigned results_owed;

  sspq_in_if  in_chan ();
  sspq_out_if out_chan ();

  stable_sorted_priority_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sspq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: far beyond the slowest legal run of about 1450 items
  initial begin
    #5_000_000;
    $display("tb_stable_sorted_priority_queue: FAIL");
    $finish;
  end

  // Offer one item after a random gap, hold it until the queue takes it.
  // valid gets at most one update per falling edge.
  task automatic send_item(logic op, logic [15:0] k, logic [31:0] p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.key       <= k;
    in_chan.payload   <= p;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
  endtask

  // Bias toward the extremes and a tiny range so equal keys are common
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stall before each result item, ready held until it leaves
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  initial begin
    int push_pct;
    logic op;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_PUSH;
    in_chan.key       = '0;
    in_chan.payload   = '0;
    no_idle           = 1'b0;
    rst_n             = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    send_item(OP_POP, 16'h0000, 32'h0);             // pop while empty
    send_item(OP_PUSH, 16'h0000, 32'h0000_0000);    // smallest key
    send_item(OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF);    // largest key
    for (int i = 1; i <= 3; i++)                    // ties keep arrival order
      send_item(OP_PUSH, 16'h1234, 32'(i));
    // fill to capacity, with ties at both key extremes
    for (int i = 0; i < 11; i++)
      send_item(OP_PUSH, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'h0800 - 16'(i),
                ~32'(i));
    send_item(OP_PUSH, 16'h0001, 32'hDEAD_BEEF);    // full: dropped
    repeat (5) send_item(OP_POP, pick_key(), pick_payload());

    // --- random: phases of 50 items, each with its own push/pop mix ---
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 20;
          1:       push_pct = 50;
          2:       push_pct = 70;
          default: push_pct = 90;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      // pops carry noise in key/payload; the queue must ignore it
      send_item(op, pick_key(), pick_payload());
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    no_idle = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_stable_sorted_priority_queue: PASS");
    end else begin
      $display("tb_stable_sorted_priority_queue: FAIL");
    end
    $finish;
  end

endmodule
